// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Shared types, codes and byte-level functions for the AES-128 mode engine.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RndW      = 4;

  typedef enum logic [1:0] {
    REQ_ENC  = 2'd0,
    REQ_DEC  = 2'd1,
    REQ_LOAD = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CTR = 2'd2,
    MODE_RSV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_MODE     = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic            load;      // capture the input block
    logic            key_start; // restart the key schedule (cipher key, or final key on decrypt)
    logic            key_step;  // advance the key schedule one round
    logic            init_add;  // apply the first round-key addition
    logic            round;     // run one cipher round
    logic            last;      // this round is the final one (the first on decrypt)
    logic            decrypt;   // inverse direction
    logic            finish;    // form the result and update the chain value
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a state, byte 0 at the top
  function automatic logic [7:0] st_byte(input logic [127:0] s, input int unsigned i);
    st_byte = s[127-8*i -: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aes_keysched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Steps the round key forward (encrypt) or backward (decrypt), one round per
// cycle while step_i is set, starting from the cipher key or the stored final round key.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_keysched
  import aes_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [127:0] key_i,
  input  wire logic         key_new_i,   // cipher key changed
  input  wire logic         start_i,
  input  wire logic         step_i,
  input  wire logic         decrypt_i,
  output logic      [127:0] rkey_o,
  output logic              busy_o       // final key being computed
);

  logic [127:0] rk_q, rk_d;
  logic [127:0] last_q, last_d;
  logic [7:0]   rc_q, rc_d;
  logic [RndW-1:0] cnt_q, cnt_d;
  logic         prep_q, prep_d;
  logic [127:0] fwd, bwd, prep_next;
  logic [7:0]   rc_fwd_prep;

  // Forward expansion of one round key
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // Backward step: recover the previous round key
  function automatic logic [127:0] prev_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, p3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    p3 = w3 ^ w2;
    t  = {SBOX[p3[23:16]] ^ rc, SBOX[p3[15:8]], SBOX[p3[7:0]], SBOX[p3[31:24]]};
    prev_key = {w0 ^ t, w1 ^ w0, w2 ^ w1, p3};
  endfunction

  function automatic logic [7:0] rc_back(input logic [7:0] rc);
    rc_back = rc[0] ? ((rc ^ 8'h1b) >> 1) | 8'h80 : rc >> 1;
  endfunction

  assign fwd = next_key(rk_q, rc_q);
  assign bwd = prev_key(rk_q, rc_q);
  assign prep_next = next_key(last_q, rc_fwd_prep);
  assign rc_fwd_prep = rc_q;
  assign rkey_o = rk_q;
  assign busy_o = prep_q;

  // Precompute the final round key after reset and every key change; else load or step
  always_comb begin
    rk_d   = rk_q;
    rc_d   = rc_q;
    last_d = last_q;
    cnt_d  = cnt_q;
    prep_d = prep_q;
    if (key_new_i) begin
      prep_d = 1'b1;
      last_d = key_i;
      rc_d   = 8'h01;
      cnt_d  = '0;
    end else if (prep_q) begin
      last_d = prep_next;
      rc_d   = xtime(rc_q);
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == RndW'(NumRounds - 1)) begin
        prep_d = 1'b0;
      end
    end else if (start_i) begin
      rk_d = decrypt_i ? last_q : key_i;
      rc_d = decrypt_i ? 8'h36 : 8'h01;
    end else if (step_i) begin
      rk_d = decrypt_i ? bwd : fwd;
      rc_d = decrypt_i ? rc_back(rc_q) : xtime(rc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= 1'b1;
      cnt_q  <= '0;
      rc_q   <= 8'h01;
      last_q <= '0;
    end else begin
      prep_q <= prep_d;
      cnt_q  <= cnt_d;
      rc_q   <= rc_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aes_datapath.sv =====
// ----------------------------------------------------------------------------
// AES datapath
// State register with one round unit, chaining value and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_datapath
  import aes_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire dp_cmd_t      cmd_i,
  input  wire in_t          in_i,
  input  wire logic [1:0]   mode_i,
  input  wire logic [127:0] rkey_i,
  output out_t              res_o
);

  logic [127:0] st_q, st_d, blk_q, cv_q, cv_d, rnd, res_q, res_d;
  logic [1:0]   req_q;
  logic [127:0] in_blk;

  assign in_blk = {in_i.block_high, in_i.block_low};

  // Forward round
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = SBOX[st_byte(s, i)];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*c+r] = b[4*((c+r)%4)+r];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    enc_round = o;
  endfunction

  // Inverse round: inverse mix on the input (skipped on the first), then
  // inverse shift and substitution; key added outside
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic first);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, u, v;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = st_byte(s, i);
    if (!first) begin
      for (int c = 0; c < 4; c++) begin
        a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
        u = a0 ^ a1 ^ a2 ^ a3;
        b[4*c]   = a0 ^ u ^ xtime(a0 ^ a1);
        b[4*c+1] = a1 ^ u ^ xtime(a1 ^ a2);
        b[4*c+2] = a2 ^ u ^ xtime(a2 ^ a3);
        b[4*c+3] = a3 ^ u ^ xtime(a3 ^ a0);
      end
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*((c+r)%4)+r] = INV_SBOX[b[4*c+r]];
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    dec_round = o;
  endfunction

  // cmd_i.last on a decrypt round marks the first inverse round
  assign rnd = cmd_i.decrypt ? dec_round(st_q, cmd_i.last) : enc_round(st_q, cmd_i.last);

  always_comb begin
    st_d  = st_q;
    cv_d  = cv_q;
    res_d = res_q;
    if (cmd_i.init_add) begin
      if (req_q == REQ_ENC && mode_i == MODE_CBC) begin
        st_d = blk_q ^ cv_q ^ rkey_i;
      end else if (mode_i == MODE_CTR) begin
        st_d = cv_q ^ rkey_i;
      end else begin
        st_d = blk_q ^ rkey_i;
      end
    end else if (cmd_i.round) begin
      st_d = rnd ^ rkey_i;
    end
    if (cmd_i.finish) begin
      case (req_q)
        REQ_LOAD: begin
          res_d = '0;
          cv_d  = blk_q;
        end
        REQ_ENC, REQ_DEC: begin
          case (mode_i)
            MODE_CBC: begin
              if (req_q == REQ_ENC) begin
                res_d = st_q;
                cv_d  = st_q;
              end else begin
                res_d = st_q ^ cv_q;
                cv_d  = blk_q;
              end
            end
            MODE_CTR: begin
              res_d = st_q ^ blk_q;
              cv_d  = cv_q + 128'd1;
            end
            default: res_d = st_q;
          endcase
        end
        default: res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else begin
      cv_q <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    res_q <= res_d;
    if (cmd_i.load) begin
      blk_q <= in_blk;
      req_q <= in_i.req_type;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aes_ctrl.sv =====
// ----------------------------------------------------------------------------
// AES controller
// Sequences key setup, initial addition, ten rounds and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ctrl
  import aes_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] req_i,
  input  wire logic [1:0] mode_i,
  input  wire logic       key_busy_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output dp_cmd_t         cmd_o,
  output logic            ks_start_o,
  output logic            ks_step_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_KEY   = 5'b00010,
    ST_INIT  = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic dec_q, dec_d, ov_q, ov_d, fin;
  logic accept;

  // Ready while nothing is in flight, the key schedule is not busy and the last result can move on
  assign in_ready_o  = (state_q == ST_IDLE) && !key_busy_i && (!ov_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    dec_d   = dec_q;
    cmd_o   = '0;
    ks_start_o = 1'b0;
    ks_step_o  = 1'b0;
    fin     = 1'b0;
    cmd_o.decrypt = dec_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          dec_d = (req_i == REQ_DEC) && (mode_i != MODE_CTR);
          ks_start_o = 1'b1;
          cmd_o.decrypt = dec_d;
          state_d = (req_i == REQ_ENC || req_i == REQ_DEC) ? ST_KEY : ST_DONE;
        end
      end
      ST_KEY: begin
        state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init_add = 1'b1;
        ks_step_o = 1'b1;
        rnd_d = RndW'(1);
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        cmd_o.last  = dec_q ? (rnd_q == RndW'(1)) : (rnd_q == RndW'(NumRounds));
        ks_step_o = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(NumRounds)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        fin = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.finish = fin;
    cmd_o.key_start = ks_start_o;
    cmd_o.key_step  = ks_step_o;
    ov_d = fin ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      dec_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      dec_q   <= dec_d;
      ov_q    <= ov_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aes128_block_cipher_modes.sv =====
// AES-128 engine with ECB, CBC and CTR modes. A transaction runs from
// acceptance through key load, initial addition, ten rounds through one
// shared round unit and result update; a load of the chaining value or an
// unused request goes straight to the result update. The round keys are
// generated on the fly; the final round key is precomputed after a key write,
// from the cycle after it on, and no transaction is accepted until it is ready.
// A new transaction is accepted only while the engine is idle and no result is
// waiting, or the waiting result is taken in the same cycle.
// ----------------------------------------------------------------------------
// AES-128 block cipher modes, top level
// Configuration registers, controller, key schedule and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_cipher_modes
  import aes_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_t             out_data_o
);

  logic [63:0]  key_hi_q, key_lo_q;
  logic [1:0]   mode_q;
  logic         key_new;
  logic [127:0] rkey;
  logic         key_busy, ks_start, ks_step;
  dp_cmd_t      cmd;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      mode_q   <= MODE_ECB;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
        CFG_KEY_LOW:  key_lo_q <= cfg_data_i;
        CFG_MODE:     mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Restart the final key precompute in the cycle after a key write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_new <= 1'b0;
    end else begin
      key_new <= cfg_we_i && (cfg_index_i == CFG_KEY_HIGH || cfg_index_i == CFG_KEY_LOW);
    end
  end

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .req_i(in_data_i.req_type), .mode_i(mode_q),
    .key_busy_i(key_busy || key_new),
    .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .ks_start_o(ks_start), .ks_step_o(ks_step)
  );

  aes_keysched u_ks (
    .clk_i, .rst_ni,
    .key_i({key_hi_q, key_lo_q}), .key_new_i(key_new),
    .start_i(ks_start), .step_i(ks_step), .decrypt_i(cmd.decrypt),
    .rkey_o(rkey), .busy_o(key_busy)
  );

  aes_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .in_i(in_data_i), .mode_i(mode_q),
    .rkey_i(rkey), .res_o(out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// AES port checker
// Watches the top-level ports for handshake and sequencing rules.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_checker
  import aes_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // No new transaction the cycle after one is accepted
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted too early");

  // A result never appears right after acceptance
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind aes128_block_cipher_modes aes_checker u_aes_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

`default_nettype wire

// ===== bench/tb_aes128_block_cipher_modes.sv =====
// ----------------------------------------------------------------------------
// AES-128 mode engine testbench
// Drives blocks in ECB, CBC, CTR and the reserved mode under several keys,
// predicts each result with a behavioral cipher model and compares every
// field in order.
module tb_aes128_block_cipher_modes;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;

  aes128_block_cipher_modes DUT (.*);

  // Predictor state
  logic [63:0]  key_hi_q, key_lo_q;
  mode_e        mode_q;
  logic [127:0] rkeys [11];
  logic [127:0] chain_q;
  logic [7:0]   inv_sb [256];

  in_t  pending_blocks [$];
  out_t expected_blocks [$];
  int   err_count;
  int   send_idle_pct, recv_idle_pct;
  int   hold_cycles;

  function automatic logic [7:0] gf_dbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] x, logic [7:0] y);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) r ^= x;
      x = gf_dbl(x);
    end
    return r;
  endfunction

  function automatic logic [7:0] byte_at(logic [127:0] s, int i);
    return s[127-8*i -: 8];
  endfunction

  task automatic expand_keys();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] tmp, rc;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = byte_at({key_hi_q, key_lo_q}, i);
    for (int n = 16; n < 176; n += 4) begin
      for (int a = 0; a < 4; a++) t[a] = w[n-4+a];
      if (n % 16 == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int a = 0; a < 4; a++) t[a] = SBOX[t[a]];
        t[0] ^= rc;
        rc = gf_dbl(rc);
      end
      for (int a = 0; a < 4; a++) w[n+a] = w[n-16+a] ^ t[a];
    end
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++) rkeys[r][127-8*i -: 8] = w[16*r+i];
  endtask

  function automatic logic [127:0] cipher_fwd(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a, b, c, d, x;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) s[i] = byte_at(blk ^ rkeys[0], i);
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
      for (int cl = 0; cl < 4; cl++)
        for (int rw = 0; rw < 4; rw++) t[4*cl+rw] = s[4*((cl+rw)%4)+rw];
      s = t;
      if (r != 10) begin
        for (int cl = 0; cl < 4; cl++) begin
          a = s[4*cl]; b = s[4*cl+1]; c = s[4*cl+2]; d = s[4*cl+3];
          x = a ^ b ^ c ^ d;
          s[4*cl]   ^= x ^ gf_dbl(a ^ b);
          s[4*cl+1] ^= x ^ gf_dbl(b ^ c);
          s[4*cl+2] ^= x ^ gf_dbl(c ^ d);
          s[4*cl+3] ^= x ^ gf_dbl(d ^ a);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= byte_at(rkeys[r], i);
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  function automatic logic [127:0] cipher_inv(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a, b, c, d;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) s[i] = byte_at(blk ^ rkeys[10], i);
    for (int r = 9; r >= 0; r--) begin
      for (int cl = 0; cl < 4; cl++)
        for (int rw = 0; rw < 4; rw++) t[4*((cl+rw)%4)+rw] = s[4*cl+rw];
      for (int i = 0; i < 16; i++) s[i] = inv_sb[t[i]] ^ byte_at(rkeys[r], i);
      if (r != 0) begin
        for (int cl = 0; cl < 4; cl++) begin
          a = s[4*cl]; b = s[4*cl+1]; c = s[4*cl+2]; d = s[4*cl+3];
          s[4*cl]   = gf_mul(a,8'h0e)^gf_mul(b,8'h0b)^gf_mul(c,8'h0d)^gf_mul(d,8'h09);
          s[4*cl+1] = gf_mul(a,8'h09)^gf_mul(b,8'h0e)^gf_mul(c,8'h0b)^gf_mul(d,8'h0d);
          s[4*cl+2] = gf_mul(a,8'h0d)^gf_mul(b,8'h09)^gf_mul(c,8'h0e)^gf_mul(d,8'h0b);
          s[4*cl+3] = gf_mul(a,8'h0b)^gf_mul(b,8'h0d)^gf_mul(c,8'h09)^gf_mul(d,8'h0e);
        end
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  // Compute the expected output block and advance the chaining value
  function automatic out_t predict_block(in_t it);
    logic [127:0] blk, res;
    req_e rq;
    blk = {it.block_high, it.block_low};
    rq = req_e'(it.req_type);
    res = '0;
    if (rq == REQ_LOAD) begin
      chain_q = blk;
    end else if (rq != REQ_NONE) begin
      if (mode_q == MODE_CBC) begin
        if (rq == REQ_ENC) begin
          res = cipher_fwd(blk ^ chain_q);
          chain_q = res;
        end else begin
          res = cipher_inv(blk) ^ chain_q;
          chain_q = blk;
        end
      end else if (mode_q == MODE_CTR) begin
        res = cipher_fwd(chain_q) ^ blk;
        chain_q = chain_q + 128'd1;
      end else begin
        res = (rq == REQ_ENC) ? cipher_fwd(blk) : cipher_inv(blk);
      end
    end
    return '{result_high: res[127:64], result_low: res[63:0]};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s got %h want %h", what, got, want);
    err_count++;
  endtask

  // Write one register while the block is idle
  task automatic write_reg(cfg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KEY_HIGH: begin key_hi_q = val; expand_keys(); end
      CFG_KEY_LOW:  begin key_lo_q = val; expand_keys(); end
      CFG_MODE:     mode_q = mode_e'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || expected_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_t rand_block(bit allow_none);
    in_t it;
    int p;
    p = $urandom_range(0, 99);
    if (p < 44) it.req_type = REQ_ENC;
    else if (p < 88) it.req_type = REQ_DEC;
    else if (p < 97 || !allow_none) it.req_type = REQ_LOAD;
    else it.req_type = REQ_NONE;
    it.block_high = rand64();
    it.block_low  = rand64();
    if ($urandom_range(0, 9) == 0) it.block_high = '1;
    if ($urandom_range(0, 9) == 0) it.block_low = '0;
    return it;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offer the next pending transaction, hold it until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_blocks.push_back(predict_block(in_data_i));
        void'(pending_blocks.pop_front());
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if ((in_valid_i && in_ready_o ? pending_blocks.size() > 0 : pending_blocks.size() > 0)
            && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_blocks[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.result_high, 64'h0);
        end else begin
          want = expected_blocks.pop_front();
          if (out_data_o.result_high !== want.result_high)
            report_mismatch("result_high", out_data_o.result_high, want.result_high);
          if (out_data_o.result_low !== want.result_low)
            report_mismatch("result_low", out_data_o.result_low, want.result_low);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and configuration phases
  initial begin
    in_t it;
    logic [63:0] keys_hi [4];
    logic [63:0] keys_lo [4];
    for (int i = 0; i < 256; i++) inv_sb[SBOX[i]] = i[7:0];
    err_count = 0;
    send_idle_pct = 18;
    recv_idle_pct = 62;
    hold_cycles = 0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_KEY_HIGH;
    cfg_data_i = '0;
    key_hi_q = '0;
    key_lo_q = '0;
    mode_q = MODE_ECB;
    chain_q = '0;
    expand_keys();
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (15) @(posedge clk_i);

    // Directed: reset key in ECB, extremes, every request
    pending_blocks.push_back('{REQ_ENC, 64'h0, 64'h0});
    pending_blocks.push_back('{REQ_DEC, 64'hffffffffffffffff, 64'hffffffffffffffff});
    pending_blocks.push_back('{REQ_NONE, 64'h0123456789abcdef, 64'hfedcba9876543210});
    pending_blocks.push_back('{REQ_LOAD, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    wait_drained();
    // Standard test vector key, then CBC both directions
    write_reg(CFG_KEY_HIGH, 64'h0001020304050607);
    write_reg(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    write_reg(CFG_NONE, 64'h1234);
    pending_blocks.push_back('{REQ_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff});
    pending_blocks.push_back('{REQ_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    wait_drained();
    write_reg(CFG_MODE, MODE_CBC);
    pending_blocks.push_back('{REQ_LOAD, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100});
    pending_blocks.push_back('{REQ_ENC, 64'h1111111111111111, 64'h2222222222222222});
    pending_blocks.push_back('{REQ_ENC, 64'h0, 64'h0});
    pending_blocks.push_back('{REQ_DEC, 64'h3333333333333333, 64'h4444444444444444});
    pending_blocks.push_back('{REQ_NONE, 64'h0, 64'h1});
    wait_drained();
    // CTR with counter wrap and unused mode
    write_reg(CFG_MODE, MODE_CTR);
    pending_blocks.push_back('{REQ_LOAD, 64'hffffffffffffffff, 64'hfffffffffffffffe});
    pending_blocks.push_back('{REQ_ENC, 64'h0, 64'h0});
    pending_blocks.push_back('{REQ_DEC, 64'h0, 64'h0});
    pending_blocks.push_back('{REQ_ENC, 64'hffffffffffffffff, 64'hffffffffffffffff});
    pending_blocks.push_back('{REQ_LOAD, 64'h0, 64'h00000000ffffffff});
    pending_blocks.push_back('{REQ_DEC, 64'h1, 64'h2});
    wait_drained();
    write_reg(CFG_MODE, MODE_RSV);
    pending_blocks.push_back('{REQ_ENC, 64'h8000000000000000, 64'h1});
    pending_blocks.push_back('{REQ_DEC, 64'h1, 64'h8000000000000000});
    wait_drained();

    // Random phases: cycle keys and modes, swap the idle profile
    keys_hi = '{64'h0, 64'hffffffffffffffff, rand64(), rand64()};
    keys_lo = '{64'hffffffffffffffff, 64'h0, rand64(), rand64()};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 62; recv_idle_pct = 18; end
      if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(CFG_KEY_HIGH, keys_hi[ph % 4]);
      write_reg(CFG_KEY_LOW, keys_lo[(ph / 4 + ph) % 4]);
      write_reg(CFG_MODE, 64'(ph % 3));
      if (ph % 3 != 0) begin
        it = '{REQ_LOAD, rand64(), rand64()};
        if (ph == 5) it = '{REQ_LOAD, 64'hffffffffffffffff, 64'hfffffffffffffffd};
        pending_blocks.push_back(it);
      end
      if (ph == 6) hold_cycles = 300;
      for (int k = 0; k < 36; k++) pending_blocks.push_back(rand_block(1'b1));
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
